// File: src/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants for the omni wheel mixer
// Widths of the stick, command, divider and pulse paths, plus the lane types.
// ----------------------------------------------------------------------------
package owm_pkg;

	localparam int StickW   = 8;
	localparam int CentW    = 9;   // centred stick, signed -127..128
	localparam int CmdW     = 10;  // mixed command, signed -383..384
	localparam int MagW     = 9;   // command magnitude, 0..384
	localparam int DvdW     = 16;  // magnitude * 127
	localparam int QW       = 7;   // scaled magnitude, 0..127
	localparam int HiSteps  = 4;   // quotient bits resolved in the first divide stage
	localparam int DbW      = 7;
	localparam int PulseW   = 11;
	localparam int OffW     = 9;   // pulse offset from stop, 0..500
	localparam int ProdW    = 32;

	localparam int CentreVal     = 127;
	localparam int FullScale     = 127;
	localparam int StopPulse     = 1500;
	localparam int DeadBandReset = 4;
	// floor(c*500/127) == (c * PulseRecip) >> RecipShift for c in 0..127
	localparam int PulseRecip    = 33026500;
	localparam int RecipShift    = 23;

	typedef struct packed {
		logic            neg;
		logic [MagW-1:0] mag;
		logic [DvdW-1:0] dvd;
	} owm_lane_t;

	typedef struct packed {
		logic            scale;
		logic [MagW-1:0] div;
	} owm_scale_t;

	function automatic logic signed [CentW-1:0] centre_stick(
		input logic [StickW-1:0] raw,
		input logic [DbW-1:0]    db
	);
		logic signed [CentW-1:0] v;
		logic [StickW-1:0]       a;
		v = $signed({1'b0, raw}) - $signed(CentW'(CentreVal));
		a = v[CentW-1] ? StickW'(-v) : v[StickW-1:0];
		if (a < StickW'(db)) begin
			v = '0;
		end
		return v;
	endfunction

endpackage

// File: src/owm_lane.sv
// ----------------------------------------------------------------------------
// owm_lane: per-wheel scale divider and pulse conversion
// Two restoring divide stages, then reciprocal multiply to the pulse width.
// ----------------------------------------------------------------------------
module owm_lane (
	input  logic                        clk,
	input  owm_pkg::owm_lane_t          lane_s2,
	input  owm_pkg::owm_scale_t         scale_s2,
	output logic [owm_pkg::PulseW-1:0]  pulse_s5
);
	import owm_pkg::*;

	logic [DvdW-1:0] rem_s3;
	logic [QW-1:0]   q_s3;
	logic [MagW-1:0] mag_s3;
	logic            neg_s3;
	owm_scale_t      scale_s3;

	logic [QW-1:0]   cmag_s4;
	logic            neg_s4;

	logic [DvdW-1:0] rem_hi;
	logic [QW-1:0]   q_hi;
	logic [DvdW-1:0] rem_lo;
	logic [QW-1:0]   q_lo;
	logic [ProdW-1:0] prod;
	logic [OffW-1:0]  off;

	// upper quotient bits; quotient never exceeds 127 since |w| <= max
	always_comb begin
		logic [DvdW-1:0] sub;
		rem_hi = lane_s2.dvd;
		q_hi   = '0;
		for (int k = QW - 1; k >= QW - HiSteps; k--) begin
			sub = DvdW'(scale_s2.div) << k;
			if (rem_hi >= sub) begin
				rem_hi  = rem_hi - sub;
				q_hi[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_s3   <= rem_hi;
		q_s3     <= q_hi;
		mag_s3   <= lane_s2.mag;
		neg_s3   <= lane_s2.neg;
		scale_s3 <= scale_s2;
	end

	always_comb begin
		logic [DvdW-1:0] sub;
		rem_lo = rem_s3;
		q_lo   = q_s3;
		for (int k = QW - HiSteps - 1; k >= 0; k--) begin
			sub = DvdW'(scale_s3.div) << k;
			if (rem_lo >= sub) begin
				rem_lo  = rem_lo - sub;
				q_lo[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmag_s4 <= scale_s3.scale ? q_lo : mag_s3[QW-1:0];
		neg_s4  <= neg_s3;
	end

	// offset is at most 500, so the pulse stays inside 1000..2000
	assign prod = ProdW'(cmag_s4) * ProdW'(PulseRecip);
	assign off  = prod[RecipShift +: OffW];

	always_ff @(posedge clk) begin
		pulse_s5 <= neg_s4 ? PulseW'(StopPulse) - PulseW'(off)
		                   : PulseW'(StopPulse) + PulseW'(off);
	end

endmodule

// File: src/omni_wheel_mixer_pulse_core.sv
// ----------------------------------------------------------------------------
// omni_wheel_mixer_pulse_core: four-wheel omni drive mixer with pulse outputs
// Timing: done is registered through v_s1..v_s5 and rises with the pulse outputs of the accepted item.
// Throughput: one item per cycle; busy is never raised, the receiver cannot stall.
// Stages: centre+mix, magnitude/max, two divide stages, pulse multiply.
// Reset: asynchronous, clears valid bits and sets dead_band to 4.
// ----------------------------------------------------------------------------
module omni_wheel_mixer_pulse_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [owm_pkg::StickW-1:0]  forward_raw,
	input  logic [owm_pkg::StickW-1:0]  strafe_raw,
	input  logic [owm_pkg::StickW-1:0]  rotate_raw,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [owm_pkg::DbW-1:0]     cfg_data,
	output logic                        done,
	output logic [owm_pkg::PulseW-1:0]  front_left_pulse,
	output logic [owm_pkg::PulseW-1:0]  front_right_pulse,
	output logic [owm_pkg::PulseW-1:0]  back_left_pulse,
	output logic [owm_pkg::PulseW-1:0]  back_right_pulse
);
	import owm_pkg::*;

	logic [DbW-1:0] dead_band_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [CentW-1:0] y, x, r;
	logic signed [CmdW-1:0]  ye, xe, re;
	logic signed [CmdW-1:0]  w_s1 [4];

	logic [MagW-1:0] mag [4];
	logic [MagW-1:0] m01, m23, mmax;

	owm_lane_t  lane_s2 [4];
	owm_scale_t scale_s2;
	logic [PulseW-1:0] pulse [4];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q <= DbW'(DeadBandReset);
		end else if (cfg_valid && cfg_ready) begin
			dead_band_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: centre, dead band, mix
	assign y  = centre_stick(forward_raw, dead_band_q);
	assign x  = centre_stick(strafe_raw, dead_band_q);
	assign r  = centre_stick(rotate_raw, dead_band_q);
	assign ye = CmdW'(y);
	assign xe = CmdW'(x);
	assign re = CmdW'(r);

	always_ff @(posedge clk) begin
		w_s1[0] <= ye + xe + re;
		w_s1[1] <= ye - xe - re;
		w_s1[2] <= -ye - xe + re;
		w_s1[3] <= -ye + xe - re;
	end

	// stage 2: magnitudes, largest magnitude, dividend
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i] = w_s1[i][CmdW-1] ? MagW'(-w_s1[i]) : w_s1[i][MagW-1:0];
		end
	end

	assign m01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
	assign m23  = (mag[2] > mag[3]) ? mag[2] : mag[3];
	assign mmax = (m01 > m23) ? m01 : m23;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			lane_s2[i].neg <= w_s1[i][CmdW-1];
			lane_s2[i].mag <= mag[i];
			lane_s2[i].dvd <= DvdW'({mag[i], 7'b0}) - DvdW'(mag[i]);
		end
		scale_s2.scale <= mmax > MagW'(FullScale);
		scale_s2.div   <= mmax;
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		owm_lane u_lane (
			.clk      (clk),
			.lane_s2  (lane_s2[g]),
			.scale_s2 (scale_s2),
			.pulse_s5 (pulse[g])
		);
	end

	assign done              = v_s5;
	assign front_left_pulse  = pulse[0];
	assign front_right_pulse = pulse[1];
	assign back_left_pulse   = pulse[2];
	assign back_right_pulse  = pulse[3];

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done)
		else $error("accepted item did not complete after five cycles");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (front_left_pulse >= PulseW'(1000) && front_left_pulse <= PulseW'(2000)
			&& back_right_pulse >= PulseW'(1000) && back_right_pulse <= PulseW'(2000)))
		else $error("pulse width out of range");

	a_centre: assert property (@(posedge clk) disable iff (!arst_n)
		(start && forward_raw == StickW'(CentreVal) && strafe_raw == StickW'(CentreVal)
			&& rotate_raw == StickW'(CentreVal))
		|-> ##5 (front_left_pulse == PulseW'(StopPulse)
			&& front_right_pulse == PulseW'(StopPulse)
			&& back_left_pulse == PulseW'(StopPulse)
			&& back_right_pulse == PulseW'(StopPulse)))
		else $error("centred sticks did not give stop pulses");
`endif

endmodule
